/* src/dsp_pkg.sv */
// shared constants, types and functions of the dsm-cc section parser
`timescale 1ns / 1ps
package dsp_pkg;

   localparam int DEFAULT_MIN_SECTION_BYTES = 12;
   localparam int DEFAULT_MAX_SECTION_BYTES = 4096;

   // wide enough for the saturated count at the largest allowed maximum
   localparam int COUNT_WIDTH   = 13;
   localparam int LENGTH_WIDTH  = 12;
   localparam int HDR_BYTES     = 20;
   localparam int HDR_IDX_WIDTH = $clog2(HDR_BYTES);
   localparam int CRC_LAG_BYTES = 4;
   localparam int STATUS_WIDTH  = 3;
   localparam int QUEUE_DEPTH   = 2;
   localparam int PTR_WIDTH     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_WIDTH    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [7:0]  CRC_TOP_BYTE_MSB = 8'h80;
   localparam logic [7:0]  DSMCC_TYPE_MSG = 8'h03;
   localparam int          NO_PAYLOAD_BYTES = 12;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_SIZE     = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_LENGTH   = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MSG_TYPE = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] STATUS_CRC      = 3'd4;

   // one finished section handed from the front to the back
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]  size;
      logic [LENGTH_WIDTH-1:0] length;
      logic                    crc_ok;
      logic [HDR_BYTES-1:0][7:0] hdr;
   } section_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [7:0]  tbl_id;
      logic [15:0] tbl_ext;
      logic [4:0]  ver_num;
      logic        current_next;
      logic [7:0]  sect_num;
      logic [7:0]  last_sect_num;
      logic [7:0]  message_type;
      logic [15:0] message_id;
      logic [31:0] transaction_id;
      logic [7:0]  adaptation_length;
      logic [15:0] message_length;
   } result_type;

   // one byte of mpeg-2 crc-32, msb first
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         if (c[31]) begin
            c = {c[30:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[30:0], 1'b0};
         end
      end
      return c;
   endfunction

   // captured header byte, zero where the section ends before the crc tail
   function automatic logic [7:0] hbyte(input logic [HDR_BYTES-1:0][7:0] hdr,
                                        input int idx,
                                        input logic [COUNT_WIDTH-1:0] size);
      logic [7:0] b;
      b = 8'h00;
      if (COUNT_WIDTH'(idx + CRC_LAG_BYTES) < size) begin
         b = hdr[idx[HDR_IDX_WIDTH-1:0]];
      end
      return b;
   endfunction

endpackage

/* src/dsp_ifs.sv */
// valid/ready channel interfaces for section bytes and parse results
`timescale 1ns / 1ps
interface dsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  tbl_id;
   logic [15:0] tbl_ext;
   logic [4:0]  ver_num;
   logic        current_next;
   logic [7:0]  sect_num;
   logic [7:0]  last_sect_num;
   logic [7:0]  message_type;
   logic [15:0] message_id;
   logic [31:0] transaction_id;
   logic [7:0]  adaptation_length;
   logic [15:0] message_length;

   modport source (output valid, output status, output tbl_id, output tbl_ext,
                   output ver_num, output current_next, output sect_num,
                   output last_sect_num, output message_type, output message_id,
                   output transaction_id, output adaptation_length, output message_length,
                   input ready);
   modport sink (input valid, input status, input tbl_id, input tbl_ext,
                 input ver_num, input current_next, input sect_num,
                 input last_sect_num, input message_type, input message_id,
                 input transaction_id, input adaptation_length, input message_length,
                 output ready);
endinterface

/* src/dsp_front.sv */
// byte front end: count, crc, tail window and header capture per section
`timescale 1ns / 1ps
module dsp_front import dsp_pkg::*; #(
   parameter int MAX_SECTION_BYTES = DEFAULT_MAX_SECTION_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   dsp_req_if.sink     req_chan,
   output logic        push_valid,
   input  logic        push_ready,
   output section_type push_data
);

   localparam logic [COUNT_WIDTH-1:0] COUNT_LIMIT = COUNT_WIDTH'(MAX_SECTION_BYTES + 1);

   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [31:0]               crc_ff, crc_in;
   logic [31:0]               tail_ff, tail_in;
   logic [LENGTH_WIDTH-1:0]   length_ff, length_in;
   logic [HDR_BYTES-1:0][7:0] hdr_ff, hdr_in;
   logic                      accept;

   assign req_chan.ready = push_ready;
   assign accept = req_chan.valid && push_ready;

   always_comb begin
      hdr_in = hdr_ff;
      if (count_ff < COUNT_WIDTH'(HDR_BYTES)) begin
         hdr_in[count_ff[HDR_IDX_WIDTH-1:0]] = req_chan.data_byte;
      end
      length_in = length_ff;
      if (count_ff == COUNT_WIDTH'(2)) begin
         length_in = {hdr_ff[1][3:0], req_chan.data_byte};
      end
      // the crc runs four bytes behind, fed from the top of the tail window
      crc_in = crc_ff;
      if (count_ff >= COUNT_WIDTH'(CRC_LAG_BYTES)) begin
         crc_in = crc_byte(crc_ff, tail_ff[31:24]);
      end
      tail_in = {tail_ff[23:0], req_chan.data_byte};
      count_in = count_ff;
      if (count_ff < COUNT_LIMIT) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_chan.last_byte)) begin
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         tail_ff   <= '0;
         length_ff <= '0;
      end else if (accept) begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         tail_ff   <= tail_in;
         length_ff <= length_in;
      end
   end

   // every byte a section reports was written during that section
   always_ff @(posedge clock) begin
      if (accept) begin
         hdr_ff <= hdr_in;
      end
   end

   assign push_valid       = accept && req_chan.last_byte;
   assign push_data.size   = count_in;
   assign push_data.length = length_in;
   assign push_data.crc_ok = (crc_in == tail_in);
   assign push_data.hdr    = hdr_in;

endmodule

/* src/dsp_queue.sv */
// short queue of finished sections between front and back
`timescale 1ns / 1ps
module dsp_queue import dsp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  section_type in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output section_type out_data
);

   section_type            entries_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FILL_WIDTH-1:0]  fill_ff;
   logic                   push, pop;

   assign in_ready  = (fill_ff != FILL_WIDTH'(QUEUE_DEPTH));
   assign out_valid = (fill_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   function automatic logic [PTR_WIDTH-1:0] next_ptr(input logic [PTR_WIDTH-1:0] p);
      logic [PTR_WIDTH-1:0] n;
      n = p + PTR_WIDTH'(1);
      if (p == PTR_WIDTH'(QUEUE_DEPTH - 1)) begin
         n = '0;
      end
      return n;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + FILL_WIDTH'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - FILL_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= in_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_WIDTH'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");
   a_fill_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (fill_ff == $past(fill_ff) + FILL_WIDTH'(1)))
      else $error("queue fill did not rise on push");
   a_fill_down: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (fill_ff == $past(fill_ff) - FILL_WIDTH'(1)))
      else $error("queue fill did not fall on pop");
`endif

endmodule

/* src/dsp_back.sv */
// back end: status decision, field masking and the result register
`timescale 1ns / 1ps
module dsp_back import dsp_pkg::*; #(
   parameter int MIN_SECTION_BYTES = DEFAULT_MIN_SECTION_BYTES,
   parameter int MAX_SECTION_BYTES = DEFAULT_MAX_SECTION_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  section_type pop_data,
   dsp_rsp_if.source   rsp_chan
);

   localparam logic [COUNT_WIDTH-1:0] SIZE_LOW  = COUNT_WIDTH'(MIN_SECTION_BYTES);
   localparam logic [COUNT_WIDTH-1:0] SIZE_HIGH = COUNT_WIDTH'(MAX_SECTION_BYTES);

   result_type             res_in, res_ff;
   logic                   valid_ff;
   logic                   load;
   logic [COUNT_WIDTH-1:0] size;
   logic [COUNT_WIDTH-1:0] length_total;
   logic [7:0]             ver_byte;

   assign size = pop_data.size;
   assign length_total = COUNT_WIDTH'(pop_data.length) + COUNT_WIDTH'(3);
   assign ver_byte = hbyte(pop_data.hdr, 5, size);

   always_comb begin
      res_in = '0;
      if (size < SIZE_LOW || size > SIZE_HIGH) begin
         res_in.status = STATUS_SIZE;
      end else begin
         res_in.tbl_id = hbyte(pop_data.hdr, 0, size);
         if (length_total != size) begin
            res_in.status = STATUS_LENGTH;
         end else begin
            res_in.status = STATUS_OK;
            res_in.tbl_ext = {hbyte(pop_data.hdr, 3, size),
                              hbyte(pop_data.hdr, 4, size)};
            res_in.ver_num       = ver_byte[5:1];
            res_in.current_next  = ver_byte[0];
            res_in.sect_num      = hbyte(pop_data.hdr, 6, size);
            res_in.last_sect_num = hbyte(pop_data.hdr, 7, size);
            // a section of header and crc only carries no message
            if (size > COUNT_WIDTH'(NO_PAYLOAD_BYTES)) begin
               res_in.message_type = hbyte(pop_data.hdr, 9, size);
               if (res_in.message_type == DSMCC_TYPE_MSG) begin
                  res_in.message_id = {hbyte(pop_data.hdr, 10, size),
                                       hbyte(pop_data.hdr, 11, size)};
                  res_in.transaction_id = {hbyte(pop_data.hdr, 12, size),
                                           hbyte(pop_data.hdr, 13, size),
                                           hbyte(pop_data.hdr, 14, size),
                                           hbyte(pop_data.hdr, 15, size)};
                  res_in.adaptation_length = hbyte(pop_data.hdr, 17, size);
                  res_in.message_length = {hbyte(pop_data.hdr, 18, size),
                                           hbyte(pop_data.hdr, 19, size)};
               end else begin
                  res_in.status = STATUS_MSG_TYPE;
               end
            end
         end
         // crc failure wins over length and type errors
         if (!pop_data.crc_ok) begin
            res_in.status = STATUS_CRC;
         end
      end
   end

   assign pop_ready = !valid_ff || rsp_chan.ready;
   assign load = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_chan.valid             = valid_ff;
   assign rsp_chan.status            = res_ff.status;
   assign rsp_chan.tbl_id            = res_ff.tbl_id;
   assign rsp_chan.tbl_ext           = res_ff.tbl_ext;
   assign rsp_chan.ver_num           = res_ff.ver_num;
   assign rsp_chan.current_next      = res_ff.current_next;
   assign rsp_chan.sect_num          = res_ff.sect_num;
   assign rsp_chan.last_sect_num     = res_ff.last_sect_num;
   assign rsp_chan.message_type      = res_ff.message_type;
   assign rsp_chan.message_id        = res_ff.message_id;
   assign rsp_chan.transaction_id    = res_ff.transaction_id;
   assign rsp_chan.adaptation_length = res_ff.adaptation_length;
   assign rsp_chan.message_length    = res_ff.message_length;

endmodule

/* src/dsmcc_section_parser.sv */
// top level of the dsm-cc section parser with crc-32 check
//
//   channel    dir   handshake     carries
//   req_chan   in    valid/ready   data_byte, last_byte
//   rsp_chan   out   valid/ready   status and the section and message header fields
//
// one byte is taken every cycle unless the section queue is full; the crc advances one byte per byte taken
// after the final byte is taken, a result becomes valid once the section has passed through the
// two-entry section queue and then the result register, so bytes keep flowing
// req_chan stalls whenever both queue entries are full
// synchronous reset clears the byte count, crc, tail window, queue and result valid
`timescale 1ns / 1ps
module dsmcc_section_parser import dsp_pkg::*; #(
   parameter int MIN_SECTION_BYTES = DEFAULT_MIN_SECTION_BYTES,
   parameter int MAX_SECTION_BYTES = DEFAULT_MAX_SECTION_BYTES
) (
   input  logic      clock,
   input  logic      reset,
   dsp_req_if.sink   req_chan,
   dsp_rsp_if.source rsp_chan
);

   logic        push_valid, push_ready;
   section_type push_data;
   logic        pop_valid, pop_ready;
   section_type pop_data;

   dsp_front #(
      .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   dsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   dsp_back #(
      .MIN_SECTION_BYTES(MIN_SECTION_BYTES),
      .MAX_SECTION_BYTES(MAX_SECTION_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_chan  (rsp_chan)
   );

endmodule
